@@ hw/rtl/event_action_rule_table_defines.svh @@
// Assertion macros shared by the event-action rule table RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef EVENT_ACTION_RULE_TABLE_DEFINES_SVH
`define EVENT_ACTION_RULE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EART_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define EART_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/eart_pkg.sv @@
// Types and codes for the event-action rule table.
// Used by eart_cell and event_action_rule_table; depends on nothing.
package eart_pkg;

	localparam int FIELD_W = 32;

	localparam logic [1:0] REQ_CHECK  = 2'd0;
	localparam logic [1:0] REQ_ADD    = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_NO_COND = 2'd2;
	localparam logic [1:0] ST_NO_ACT  = 2'd3;

	typedef struct packed {
		logic [1:0]         req_type;
		logic [FIELD_W-1:0] condition_states;
		logic [FIELD_W-1:0] new_conditions;
		logic [FIELD_W-1:0] new_actions;
		logic [3:0]         target_position;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               fired;
		logic [3:0]         fired_position;
		logic [FIELD_W-1:0] fired_actions;
		logic [4:0]         rule_count;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic chk;
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

@@ hw/rtl/eart_cell.sv @@
// One rule slot of the table: condition mask, action mask, armed flag.
// Depends on eart_pkg; takes its neighbor's contents on a remove shift.
module eart_cell #(
	parameter int COND_BITS   = 32,
	parameter int ACTION_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  eart_pkg::cell_ctl_t      ctl,
	input  logic [COND_BITS-1:0]     states,
	input  logic [COND_BITS-1:0]     new_cond,
	input  logic [ACTION_BITS-1:0]   new_act,
	input  logic [COND_BITS-1:0]     nb_cond,
	input  logic [ACTION_BITS-1:0]   nb_act,
	input  logic                     nb_armed,
	output logic [COND_BITS-1:0]     cond,
	output logic [ACTION_BITS-1:0]   act,
	output logic                     armed,
	output logic                     fire
);

	logic [COND_BITS-1:0]   cond_q;
	logic [ACTION_BITS-1:0] act_q;
	logic                   armed_q;
	logic                   hit;

	assign hit   = (cond_q != '0) && ((cond_q & ~states) == '0);
	assign fire  = ctl.chk && hit && !armed_q;
	assign cond  = cond_q;
	assign act   = act_q;
	assign armed = armed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
		end else begin
			if (ctl.chk) begin
				armed_q <= hit;
			end else if (ctl.load) begin
				armed_q <= 1'b0;
			end else if (ctl.shift) begin
				armed_q <= nb_armed;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cond_q <= new_cond;
			act_q  <= new_act;
		end else if (ctl.shift) begin
			cond_q <= nb_cond;
			act_q  <= nb_act;
		end
	end

endmodule

@@ hw/rtl/event_action_rule_table.sv @@
// Top level of the event-action rule table: a chain of rule cells and the request sequencer.
// Depends on eart_pkg, eart_cell and event_action_rule_table_defines.svh.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low; its fields
//   arrive as one req struct. Results leave on rsp, each valid for exactly one
//   cycle while done is high; rsp.last marks the final result of a request.
//   The receiver cannot hold results off, so none are ever stalled.
//   Add, remove and unknown requests answer in the cycle after acceptance and leave
//   busy low, so a new request may follow in the very next cycle.
//   A check evaluates every held rule in its cell in the accept cycle. If none
//   fires, one empty result follows in the next cycle. Otherwise busy rises and the
//   sequencer walks positions from newest to oldest, one per cycle, emitting a
//   result for each firing rule. A remove shifts all newer cells down by one.
//   Reset clears the rule count, all armed flags and the sequencer; the
//   mask registers in the cells are not reset and are never read before written.
`include "event_action_rule_table_defines.svh"

module event_action_rule_table #(
	parameter int RULES       = 16,
	parameter int COND_BITS   = 32,
	parameter int ACTION_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  eart_pkg::req_t req,
	output logic          done,
	output eart_pkg::rsp_t rsp
);

	localparam int IDX_W = (RULES > 1) ? $clog2(RULES) : 1;
	localparam int CNT_W = $clog2(RULES + 1);
	localparam int CW    = (CNT_W > 4) ? CNT_W : 4;
	localparam logic [CNT_W-1:0] RULES_CNT = CNT_W'(RULES);

	logic [CNT_W-1:0]       held_q, held_d;
	logic                   busy_q, busy_d;
	logic [RULES-1:0]       pend_q, pend_d, pend_nxt;
	logic [IDX_W-1:0]       ptr_q, ptr_d;
	logic                   done_q, emit;
	eart_pkg::rsp_t         rsp_q, rsp_d;

	logic                   acc, add_ok, rm_ok;
	logic [CW-1:0]          held_w, tpos_w;
	logic [COND_BITS-1:0]   states, new_cond;
	logic [ACTION_BITS-1:0] new_act;

	eart_pkg::cell_ctl_t    ctl [RULES];
	logic [COND_BITS-1:0]   cond [RULES];
	logic [ACTION_BITS-1:0] act [RULES];
	logic [RULES-1:0]       armed, fire;

	assign acc      = start && !busy_q;
	assign held_w   = CW'(held_q);
	assign tpos_w   = CW'(req.target_position);
	assign states   = req.condition_states[COND_BITS-1:0];
	assign new_cond = req.new_conditions[COND_BITS-1:0];
	assign new_act  = req.new_actions[ACTION_BITS-1:0];

	for (genvar i = 0; i < RULES; i++) begin : g_cell
		logic [COND_BITS-1:0]   nb_cond;
		logic [ACTION_BITS-1:0] nb_act;
		logic                   nb_armed;

		if (i == RULES - 1) begin : g_end
			assign nb_cond  = '0;
			assign nb_act   = '0;
			assign nb_armed = 1'b0;
		end else begin : g_mid
			assign nb_cond  = cond[i+1];
			assign nb_act   = act[i+1];
			assign nb_armed = armed[i+1];
		end

		assign ctl[i].chk   = acc && (req.req_type == eart_pkg::REQ_CHECK) &&
			(CW'(i) < held_w);
		assign ctl[i].load  = add_ok && (CW'(i) == held_w);
		assign ctl[i].shift = rm_ok && (CW'(i) >= tpos_w);

		eart_cell #(
			.COND_BITS   (COND_BITS),
			.ACTION_BITS (ACTION_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[i]),
			.states   (states),
			.new_cond (new_cond),
			.new_act  (new_act),
			.nb_cond  (nb_cond),
			.nb_act   (nb_act),
			.nb_armed (nb_armed),
			.cond     (cond[i]),
			.act      (act[i]),
			.armed    (armed[i]),
			.fire     (fire[i])
		);
	end

	always_comb begin
		for (int i = 0; i < RULES; i++) begin
			pend_nxt[i] = pend_q[i] && (IDX_W'(i) != ptr_q);
		end
	end

	always_comb begin
		rsp_d        = '0;
		rsp_d.status = eart_pkg::ST_OK;
		rsp_d.last   = 1'b1;
		emit         = 1'b0;
		busy_d       = busy_q;
		pend_d       = pend_q;
		ptr_d        = ptr_q;
		held_d       = held_q;
		add_ok       = 1'b0;
		rm_ok        = 1'b0;
		if (busy_q) begin
			if (pend_q[ptr_q]) begin
				emit                 = 1'b1;
				rsp_d.fired          = 1'b1;
				rsp_d.fired_position = 4'(ptr_q);
				rsp_d.fired_actions  = eart_pkg::FIELD_W'(act[ptr_q]);
				rsp_d.last           = (pend_nxt == '0);
			end
			pend_d = pend_nxt;
			busy_d = (pend_nxt != '0);
			ptr_d  = ptr_q - 1'b1;
		end else if (start) begin
			emit = 1'b1;
			unique case (req.req_type)
				eart_pkg::REQ_CHECK: begin
					if (fire != '0) begin
						emit   = 1'b0;
						busy_d = 1'b1;
						pend_d = fire;
						ptr_d  = IDX_W'(held_q - 1'b1);
					end
				end
				eart_pkg::REQ_ADD: begin
					priority if (held_q >= RULES_CNT) begin
						rsp_d.status = eart_pkg::ST_RANGE;
					end else if (new_cond == '0) begin
						rsp_d.status = eart_pkg::ST_NO_COND;
					end else if (new_act == '0) begin
						rsp_d.status = eart_pkg::ST_NO_ACT;
					end else begin
						add_ok = 1'b1;
						held_d = held_q + 1'b1;
					end
				end
				eart_pkg::REQ_REMOVE: begin
					if (tpos_w >= held_w) begin
						rsp_d.status = eart_pkg::ST_RANGE;
					end else begin
						rm_ok  = 1'b1;
						held_d = held_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		rsp_d.rule_count = 5'(held_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			busy_q <= 1'b0;
			pend_q <= '0;
			ptr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			held_q <= held_d;
			busy_q <= busy_d;
			pend_q <= pend_d;
			ptr_q  <= ptr_d;
			done_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

	`EART_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, held_q <= RULES_CNT, "rule count exceeds table depth")
	`EART_ASSERT_IMP(a_busy_pending, clk, arst_n, busy_q, pend_q != '0, "walk active with no pending firing")
	`EART_ASSERT_IMP(a_more_follow, clk, arst_n, done_q && !rsp_q.last, busy_q, "non-final result without an active walk")
	`EART_ASSERT_NXT(a_walk_count, clk, arst_n, busy_q, $stable(held_q), "rule count changed during a check walk")

endmodule

@@ bench/tb.sv @@
// Self-checking bench for event_action_rule_table: directed and random add, remove, check and unknown
// requests under several sender idle rates. Depends on eart_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb;

	localparam int RULES = 16;
	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_GAP = 60;
	localparam int SHOWN_MISMATCHES = 10;

	class rule_table_tracker;
		logic [31:0] cond_masks[RULES];
		logic [31:0] action_masks[RULES];
		bit armed[RULES];
		int rule_total;
		eart_pkg::rsp_t answers_due[$];
		int mismatches;
		int checked;
		int requests;
		int firings;
		int peak_rules;

		function bit covered(int i, logic [31:0] states);
			return cond_masks[i] != 0 && (cond_masks[i] & ~states) == 0;
		endfunction

		function void owe(logic [1:0] st, logic hit, int pos, logic [31:0] acts, logic tail);
			eart_pkg::rsp_t a;
			a.status = st;
			a.fired = hit;
			a.fired_position = pos[3:0];
			a.fired_actions = acts;
			a.rule_count = rule_total[4:0];
			a.last = tail;
			answers_due.push_back(a);
		endfunction

		function void note_request(eart_pkg::req_t r);
			logic [1:0] st;
			int lowest;
			st = eart_pkg::ST_OK;
			requests++;
			case (r.req_type)
				eart_pkg::REQ_CHECK: begin
					lowest = -1;
					for (int i = rule_total - 1; i >= 0; i--)
						if (covered(i, r.condition_states) && !armed[i])
							lowest = i;
					for (int i = rule_total - 1; i >= 0; i--) begin
						if (covered(i, r.condition_states)) begin
							if (!armed[i]) begin
								armed[i] = 1'b1;
								owe(eart_pkg::ST_OK, 1'b1, i, action_masks[i], i == lowest);
								firings++;
							end
						end else begin
							armed[i] = 1'b0;
						end
					end
					if (lowest < 0)
						owe(eart_pkg::ST_OK, 1'b0, 0, '0, 1'b1);
					return;
				end
				eart_pkg::REQ_ADD: begin
					if (rule_total >= RULES) begin
						st = eart_pkg::ST_RANGE;
					end else if (r.new_conditions == 0) begin
						st = eart_pkg::ST_NO_COND;
					end else if (r.new_actions == 0) begin
						st = eart_pkg::ST_NO_ACT;
					end else begin
						cond_masks[rule_total] = r.new_conditions;
						action_masks[rule_total] = r.new_actions;
						armed[rule_total] = 1'b0;
						rule_total++;
						if (rule_total > peak_rules)
							peak_rules = rule_total;
					end
				end
				eart_pkg::REQ_REMOVE: begin
					if (r.target_position >= rule_total) begin
						st = eart_pkg::ST_RANGE;
					end else begin
						for (int i = r.target_position; i + 1 < rule_total; i++) begin
							cond_masks[i] = cond_masks[i + 1];
							action_masks[i] = action_masks[i + 1];
							armed[i] = armed[i + 1];
						end
						rule_total--;
						armed[rule_total] = 1'b0;
					end
				end
				default: begin
				end
			endcase
			owe(st, 1'b0, 0, '0, 1'b1);
		endfunction

		function void fault(string msg);
			mismatches++;
			if (mismatches <= SHOWN_MISMATCHES)
				$display("%0t: %s", $time, msg);
		endfunction

		function void check_result(eart_pkg::rsp_t got);
			eart_pkg::rsp_t want;
			checked++;
			if (answers_due.size() == 0) begin
				fault($sformatf("unexpected result st=%0d fired=%0d pos=%0d act=%h cnt=%0d last=%0d",
					got.status, got.fired, got.fired_position, got.fired_actions,
					got.rule_count, got.last));
				return;
			end
			want = answers_due.pop_front();
			if (got.status !== want.status || got.fired !== want.fired ||
					got.fired_position !== want.fired_position ||
					got.fired_actions !== want.fired_actions ||
					got.rule_count !== want.rule_count || got.last !== want.last)
				fault($sformatf({"result mismatch: expected st=%0d fired=%0d pos=%0d act=%h ",
					"cnt=%0d last=%0d, got st=%0d fired=%0d pos=%0d act=%h cnt=%0d last=%0d"},
					want.status, want.fired, want.fired_position, want.fired_actions,
					want.rule_count, want.last, got.status, got.fired, got.fired_position,
					got.fired_actions, got.rule_count, got.last));
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	eart_pkg::req_t req = '0;
	logic done;
	eart_pkg::rsp_t rsp;

	rule_table_tracker tracker = new;
	int idle_pct = 0;
	int stall_cycles = 0;

	event_action_rule_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_result(rsp);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic eart_pkg::req_t make_req(logic [1:0] kind, logic [31:0] states,
			logic [31:0] conds, logic [31:0] acts, logic [3:0] pos);
		eart_pkg::req_t r;
		r.req_type = kind;
		r.condition_states = states;
		r.new_conditions = conds;
		r.new_actions = acts;
		r.target_position = pos;
		return r;
	endfunction

	function automatic logic [31:0] sparse_mask();
		logic [31:0] m;
		int bits;
		m = '0;
		bits = $urandom_range(3, 1);
		repeat (bits) m[5'($urandom_range(31))] = 1'b1;
		return m;
	endfunction

	function automatic logic [31:0] pick_states();
		logic [31:0] s;
		int mode;
		s = '0;
		mode = $urandom_range(9);
		case (mode)
			0: s = '1;
			1: s = '0;
			2, 3: s = $urandom;
			4, 5: s = $urandom | $urandom | $urandom;
			default: begin
				for (int i = 0; i < tracker.rule_total; i++)
					if ($urandom_range(1))
						s |= tracker.cond_masks[i];
				if ($urandom_range(1))
					s |= sparse_mask();
			end
		endcase
		return s;
	endfunction

	function automatic eart_pkg::req_t random_req();
		eart_pkg::req_t r;
		int pick;
		int add_pct;
		int drop_pct;
		r = make_req(eart_pkg::REQ_CHECK, $urandom, $urandom, $urandom,
			4'($urandom_range(15)));
		add_pct = tracker.rule_total < 4 ? 45 : 25;
		drop_pct = tracker.rule_total >= 12 ? 35 : 12;
		pick = $urandom_range(99);
		if (pick < 4) begin
			r.req_type = REQ_SPARE;
		end else if (pick < 4 + add_pct) begin
			r.req_type = eart_pkg::REQ_ADD;
			if ($urandom_range(4) != 0)
				r.new_conditions = sparse_mask();
			pick = $urandom_range(19);
			if (pick == 0)
				r.new_conditions = '0;
			else if (pick == 1)
				r.new_actions = '0;
		end else if (pick < 4 + add_pct + drop_pct) begin
			r.req_type = eart_pkg::REQ_REMOVE;
			if (tracker.rule_total > 0 && $urandom_range(9) != 0)
				r.target_position = 4'($urandom_range(tracker.rule_total - 1));
		end else begin
			r.req_type = eart_pkg::REQ_CHECK;
			r.condition_states = pick_states();
		end
		return r;
	endfunction

	task automatic send(input eart_pkg::req_t r);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		tracker.note_request(r);
	endtask

	task automatic run_directed();
		send(make_req(eart_pkg::REQ_CHECK, '1, '0, '0, '0));
		send(make_req(eart_pkg::REQ_ADD, '0, '0, '1, '0));
		send(make_req(eart_pkg::REQ_ADD, '0, '1, '0, '0));
		send(make_req(eart_pkg::REQ_ADD, '0, '0, '0, '0));
		send(make_req(eart_pkg::REQ_REMOVE, '0, '0, '0, '0));
		send(make_req(REQ_SPARE, '1, '1, '1, 4'hf));
		send(make_req(eart_pkg::REQ_ADD, '0, '1, '1, '0));
		send(make_req(eart_pkg::REQ_ADD, '0, 32'h8000_0000, 32'h0000_0001, '0));
		for (int k = 2; k < RULES; k++)
			send(make_req(eart_pkg::REQ_ADD, '0, sparse_mask(), $urandom | (32'd1 << k), '0));
		send(make_req(eart_pkg::REQ_ADD, '0, '0, '0, '0));
		send(make_req(eart_pkg::REQ_CHECK, '1, '0, '0, '0));
		send(make_req(eart_pkg::REQ_CHECK, '1, '0, '0, '0));
		send(make_req(eart_pkg::REQ_CHECK, 32'h8000_0000, '0, '0, '0));
		send(make_req(eart_pkg::REQ_REMOVE, '0, '0, '0, 4'hf));
		send(make_req(eart_pkg::REQ_REMOVE, '0, '0, '0, 4'h0));
		send(make_req(eart_pkg::REQ_REMOVE, '0, '0, '0, 4'hf));
		send(make_req(eart_pkg::REQ_CHECK, '1, '0, '0, '0));
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idle_pct = 0;
		run_directed();
		repeat (24) send(random_req());
		idle_pct = 75;
		repeat (23) send(random_req());
		idle_pct = 16;
		repeat (23) send(random_req());
		start <= 1'b0;

		while (tracker.answers_due.size() != 0)
			@(posedge clk);
		repeat (RULES + 4) @(posedge clk);

		$display("covered %0d requests at idle rates 0, 75 and 16 percent, table peak %0d of %0d",
			tracker.requests, tracker.peak_rules, RULES);
		$display("checked %0d results with %0d rule firings, %0d mismatches",
			tracker.checked, tracker.firings, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.answers_due.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/eart_pkg.sv
hw/rtl/eart_cell.sv
hw/rtl/event_action_rule_table.sv
bench/tb.sv
